// ===== sv/stack_blur_line_filter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Stack blur line filter assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef STACK_BLUR_LINE_FILTER_UNIT_DEFINES_SVH
`define STACK_BLUR_LINE_FILTER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define SBL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define SBL_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers reset itself
`define SBL_ASSERT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sbl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack blur line filter package
// Widths, defaults and shared types of the line filter.
// ----------------------------------------------------------------------------
package sbl_pkg;

   localparam int MAX_RADIUS_DEFAULT = 31;
   localparam int NUM_CH             = 4;
   localparam int CH_W               = 8;
   localparam int RADIUS_W           = 5;
   localparam int CNT_W              = 6;
   localparam int SUM_W              = 18;
   localparam int DIV_W              = 11;
   localparam int Q_BITS             = 8;
   localparam int FIFO_DEPTH         = 2;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd1;

   typedef logic [NUM_CH-1:0][CH_W-1:0]  pixel_type;
   typedef logic [NUM_CH-1:0][SUM_W-1:0] sum_vec_type;

   typedef struct packed {
      pixel_type pixel;
      logic      last;
      logic      first;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== sv/sbl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack blur front end
// Accepts pixels, marks the first pixel of each line, and queues them.
// ----------------------------------------------------------------------------
module sbl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  sbl_pkg::pixel_type pixel,
   input  logic               last,
   output sbl_pkg::head_type  head,
   input  logic               head_pop
);

   localparam int DEPTH = sbl_pkg::FIFO_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   sbl_pkg::entry_type        queue_ff [DEPTH];
   logic [PW-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      line_start_ff, line_start_in;
   logic                      do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = head_pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.entry = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      count_in      = count_ff;
      line_start_in = line_start_ff;
      if (do_push) begin
         wr_ptr_in     = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         line_start_in = last;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         line_start_ff <= 1'b1;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         line_start_ff <= line_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= '{pixel: pixel, last: last, first: line_start_ff};
      end
   end

endmodule

// ===== sv/sbl_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack blur divider
// Four-lane restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbl_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  sbl_pkg::sum_vec_type         dividend,
   input  logic [sbl_pkg::DIV_W-1:0]    divisor,
   output sbl_pkg::div_status_type      status,
   output sbl_pkg::pixel_type           quotient
);

   localparam int SW = $clog2(sbl_pkg::Q_BITS);

   sbl_pkg::sum_vec_type           rem_ff, rem_in;
   sbl_pkg::pixel_type             q_ff, q_in;
   logic [sbl_pkg::DIV_W-1:0]      d_ff, d_in;
   logic [SW-1:0]                  step_ff, step_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [sbl_pkg::SUM_W-1:0]      d_shift;

   assign d_shift  = {{(sbl_pkg::SUM_W - sbl_pkg::DIV_W){1'b0}}, d_ff} << step_ff;
   assign status   = '{busy: busy_ff, done: done_ff};
   assign quotient = q_ff;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         q_in    = '0;
         d_in    = divisor;
         step_in = SW'(sbl_pkg::Q_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int c = 0; c < sbl_pkg::NUM_CH; c++) begin
            if (rem_ff[c] >= d_shift) begin
               rem_in[c]        = rem_ff[c] - d_shift;
               q_in[c][step_ff] = 1'b1;
            end
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

endmodule

// ===== sv/sbl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack blur back end
// Pixel ring, window sequencer, weighted sum and result register.
// ----------------------------------------------------------------------------
module sbl_back #(
   parameter int MAX_RADIUS = sbl_pkg::MAX_RADIUS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sbl_pkg::RADIUS_W-1:0]  radius,
   input  sbl_pkg::head_type             head,
   output logic                          head_pop,
   output logic                          out_valid,
   output sbl_pkg::pixel_type            out_pixel,
   output logic                          out_eol,
   input  logic                          out_pop
);

   localparam int DEPTH = 2 * MAX_RADIUS + 1;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int RW    = sbl_pkg::RADIUS_W;
   localparam int CW    = sbl_pkg::CNT_W;
   localparam int SW    = sbl_pkg::SUM_W;
   localparam int DW    = sbl_pkg::DIV_W;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_WRITE  = 8'b0000_0010,
      ST_ACC    = 8'b0000_0100,
      ST_DRAIN  = 8'b0000_1000,
      ST_DSTART = 8'b0001_0000,
      ST_DWAIT  = 8'b0010_0000,
      ST_OUT    = 8'b0100_0000,
      ST_STEP   = 8'b1000_0000
   } back_state_type;

   back_state_type                 state_ff, state_in;
   sbl_pkg::pixel_type             ring_ff [DEPTH];
   sbl_pkg::pixel_type             px_ff, px_in;
   logic                           last_ff, last_in;
   logic [RW-1:0]                  r_ff, r_in;
   logic [DW-1:0]                  divisor_ff, divisor_in;
   logic [CW-1:0]                  seen_ff, seen_in;
   logic [CW-1:0]                  wr_left_ff, wr_left_in;
   logic [RW-1:0]                  step_left_ff, step_left_in;
   logic [PTR_W-1:0]               ptr_ff, ptr_in;
   logic [PTR_W-1:0]               rd_idx_ff, rd_idx_in;
   logic [CW-1:0]                  k_ff, k_in;
   logic [CW-1:0]                  w_ff, w_in;
   sbl_pkg::pixel_type             rd_q_ff;
   logic [CW-1:0]                  wq_ff, wq_in;
   logic                           vq_ff, vq_in;
   sbl_pkg::sum_vec_type           acc_ff, acc_in;
   logic                           out_vld_ff, out_vld_in;
   sbl_pkg::pixel_type             out_px_ff, out_px_in;
   logic                           out_eol_ff, out_eol_in;

   logic [RW-1:0]                  r_eff;
   logic [CW-1:0]                  rp1_eff, rp1;
   logic [2*CW-1:0]                rp1_sq;
   logic [CW-1:0]                  seen_nxt;
   logic [PTR_W-1:0]               ptr_nxt, rd_dec;
   logic                           div_start;
   sbl_pkg::div_status_type        div_status;
   sbl_pkg::pixel_type             div_q;

   always_comb begin
      r_eff = radius;
      if (r_eff == '0) begin
         r_eff = RW'(1);
      end
      if (32'(r_eff) > MAX_RADIUS) begin
         r_eff = RW'(MAX_RADIUS);
      end
   end

   assign rp1_eff  = {{(CW - RW){1'b0}}, r_eff} + 1'b1;
   assign rp1_sq   = rp1_eff * rp1_eff;
   assign rp1      = {{(CW - RW){1'b0}}, r_ff} + 1'b1;
   assign seen_nxt = (seen_ff < rp1) ? seen_ff + 1'b1 : seen_ff;
   assign ptr_nxt  = (ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
   assign rd_dec   = (rd_idx_ff == '0) ? PTR_W'(DEPTH - 1) : rd_idx_ff - 1'b1;

   assign out_valid = out_vld_ff;
   assign out_pixel = out_px_ff;
   assign out_eol   = out_eol_ff;

   sbl_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (divisor_ff),
      .status   (div_status),
      .quotient (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      last_in      = last_ff;
      r_in         = r_ff;
      divisor_in   = divisor_ff;
      seen_in      = seen_ff;
      wr_left_in   = wr_left_ff;
      step_left_in = step_left_ff;
      ptr_in       = ptr_ff;
      rd_idx_in    = rd_idx_ff;
      k_in         = k_ff;
      w_in         = w_ff;
      wq_in        = wq_ff;
      vq_in        = 1'b0;
      acc_in       = acc_ff;
      out_vld_in   = out_vld_ff;
      out_px_in    = out_px_ff;
      out_eol_in   = out_eol_ff;
      head_pop     = 1'b0;
      div_start    = 1'b0;

      if (vq_ff) begin
         for (int c = 0; c < sbl_pkg::NUM_CH; c++) begin
            acc_in[c] = acc_ff[c] + SW'(rd_q_ff[c]) * SW'(wq_ff);
         end
      end
      if (out_pop && out_vld_ff) begin
         out_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               head_pop     = 1'b1;
               px_in        = head.entry.pixel;
               last_in      = head.entry.last;
               r_in         = r_eff;
               divisor_in   = DW'(rp1_sq);
               seen_in      = (seen_ff > rp1_eff) ? rp1_eff : seen_ff;
               wr_left_in   = head.entry.first ? rp1_eff : CW'(1);
               step_left_in = head.entry.last ? r_eff : '0;
               state_in     = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ptr_in     = ptr_nxt;
            wr_left_in = wr_left_ff - 1'b1;
            if (wr_left_ff == CW'(1)) begin
               seen_in   = seen_nxt;
               rd_idx_in = ptr_nxt;
               k_in      = '0;
               w_in      = CW'(1);
               acc_in    = '0;
               state_in  = (seen_nxt == rp1) ? ST_ACC : ST_STEP;
            end
         end
         ST_ACC: begin
            vq_in     = 1'b1;
            wq_in     = w_ff;
            rd_idx_in = rd_dec;
            k_in      = k_ff + 1'b1;
            w_in      = (k_ff < {{(CW - RW){1'b0}}, r_ff}) ? w_ff + 1'b1 : w_ff - 1'b1;
            if (k_ff == {r_ff, 1'b0}) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            if (!div_status.busy) begin
               div_start = 1'b1;
               state_in  = ST_DWAIT;
            end
         end
         ST_DWAIT: begin
            if (div_status.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_vld_ff) begin
               out_vld_in = 1'b1;
               out_px_in  = div_q;
               out_eol_in = last_ff && (step_left_ff == '0);
               state_in   = ST_STEP;
            end
         end
         ST_STEP: begin
            if (step_left_ff != '0) begin
               step_left_in = step_left_ff - 1'b1;
               wr_left_in   = CW'(1);
               state_in     = ST_WRITE;
            end else begin
               if (last_ff) begin
                  seen_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         seen_ff    <= '0;
         ptr_ff     <= '0;
         rd_idx_ff  <= '0;
         vq_ff      <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         seen_ff    <= seen_in;
         ptr_ff     <= ptr_in;
         rd_idx_ff  <= rd_idx_in;
         vq_ff      <= vq_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      last_ff      <= last_in;
      r_ff         <= r_in;
      divisor_ff   <= divisor_in;
      wr_left_ff   <= wr_left_in;
      step_left_ff <= step_left_in;
      k_ff         <= k_in;
      w_ff         <= w_in;
      wq_ff        <= wq_in;
      acc_ff       <= acc_in;
      out_px_ff    <= out_px_in;
      out_eol_ff   <= out_eol_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         ring_ff[ptr_nxt] <= px_ff;
      end
      rd_q_ff <= ring_ff[rd_idx_ff];
   end

endmodule

// ===== sv/stack_blur_line_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack blur line filter unit
// One RGBA pixel per transfer in, the stack-blurred line out in order.
// ----------------------------------------------------------------------------
// Pixels queue in a two-entry input buffer while the back end works. Each
// pixel costs one ring write, or R+1 writes for the first pixel of a line; a
// pixel marked last of line adds R more writes and flushes up to R+1 results.
// For each result the window sum reads the ring memory one entry per cycle
// over 2R+1 entries, then a four-lane divider retires one quotient bit per
// cycle. Results wait in an output register until popped. There is no
// clearing pass after reset. Write the radius only while the unit is idle;
// 0 acts as 1 and values above MAX_RADIUS act as MAX_RADIUS.
// ----------------------------------------------------------------------------
module stack_blur_line_filter_unit #(
   parameter int MAX_RADIUS = sbl_pkg::MAX_RADIUS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [sbl_pkg::CH_W-1:0]      req_channel_0,
   input  logic [sbl_pkg::CH_W-1:0]      req_channel_1,
   input  logic [sbl_pkg::CH_W-1:0]      req_channel_2,
   input  logic [sbl_pkg::CH_W-1:0]      req_channel_3,
   input  logic                          req_last_in_line,
   output logic                          empty,
   input  logic                          pop,
   output logic [sbl_pkg::CH_W-1:0]      rsp_out_channel_0,
   output logic [sbl_pkg::CH_W-1:0]      rsp_out_channel_1,
   output logic [sbl_pkg::CH_W-1:0]      rsp_out_channel_2,
   output logic [sbl_pkg::CH_W-1:0]      rsp_out_channel_3,
   output logic                          rsp_end_of_line,
   input  logic                          csr_write_enable,
   input  logic [sbl_pkg::RADIUS_W-1:0]  csr_write_data
);

   logic [sbl_pkg::RADIUS_W-1:0]  radius_ff, radius_in;
   sbl_pkg::pixel_type            req_pixel;
   sbl_pkg::head_type             head;
   logic                          head_pop;
   logic                          out_valid;
   sbl_pkg::pixel_type            out_pixel;
   logic                          out_eol;

   assign req_pixel = {req_channel_3, req_channel_2, req_channel_1, req_channel_0};
   assign radius_in = csr_write_enable ? csr_write_data : radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= sbl_pkg::RADIUS_RESET;
      end else begin
         radius_ff <= radius_in;
      end
   end

   sbl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .pixel    (req_pixel),
      .last     (req_last_in_line),
      .head     (head),
      .head_pop (head_pop)
   );

   sbl_back #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .radius    (radius_ff),
      .head      (head),
      .head_pop  (head_pop),
      .out_valid (out_valid),
      .out_pixel (out_pixel),
      .out_eol   (out_eol),
      .out_pop   (pop)
   );

   assign empty             = !out_valid;
   assign rsp_out_channel_0 = out_pixel[0];
   assign rsp_out_channel_1 = out_pixel[1];
   assign rsp_out_channel_2 = out_pixel[2];
   assign rsp_out_channel_3 = out_pixel[3];
   assign rsp_end_of_line   = out_eol;

endmodule

// ===== sv/sbl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack blur port checker
// Port-level checks on the queue-style channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "stack_blur_line_filter_unit_defines.svh"

module sbl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          push,
   input logic                          full,
   input logic                          empty,
   input logic                          pop,
   input logic [sbl_pkg::CH_W-1:0]      rsp_out_channel_0,
   input logic [sbl_pkg::CH_W-1:0]      rsp_out_channel_1,
   input logic [sbl_pkg::CH_W-1:0]      rsp_out_channel_2,
   input logic [sbl_pkg::CH_W-1:0]      rsp_out_channel_3,
   input logic                          rsp_end_of_line
);

   logic [sbl_pkg::NUM_CH*sbl_pkg::CH_W:0] rsp_bus;

   assign rsp_bus = {rsp_end_of_line, rsp_out_channel_3, rsp_out_channel_2,
                     rsp_out_channel_1, rsp_out_channel_0};

   `SBL_ASSERT_RST(a_reset_clears, reset, empty && !full, "queues not empty after reset")

   `SBL_ASSERT_NXT(a_rsp_hold, !empty && !pop, !empty && $stable(rsp_bus), "waiting result changed")

   `SBL_ASSERT_IMP(a_full_needs_push, $rose(full) && !$past(reset), $past(push), "full without push")

   `SBL_ASSERT_IMP(a_empty_needs_pop, $rose(empty) && !$past(reset), $past(pop), "result dropped")

endmodule

bind stack_blur_line_filter_unit sbl_checker u_sbl_checker (.*);
